### rtl/pipw_pkg.sv
// Shared types, constants and helpers for the quadrant winding point-in-polygon core.
package pipw_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned SUM_BITS = 14;
  localparam int unsigned DELTA_BITS = 3;

  typedef logic [1:0] quad_t;

  localparam quad_t QUAD_PP = 2'd0;  // dx >= 0, dy >= 0
  localparam quad_t QUAD_NP = 2'd1;  // dx <  0, dy >= 0
  localparam quad_t QUAD_NN = 2'd2;  // dx <  0, dy <  0
  localparam quad_t QUAD_PN = 2'd3;  // dx >= 0, dy <  0

  localparam logic signed [DELTA_BITS-1:0] DELTA_ZERO  = 3'sd0;
  localparam logic signed [DELTA_BITS-1:0] DELTA_CCW1  = 3'sd1;
  localparam logic signed [DELTA_BITS-1:0] DELTA_CW1   = -3'sd1;
  localparam logic signed [DELTA_BITS-1:0] DELTA_CCW2  = 3'sd2;
  localparam logic signed [DELTA_BITS-1:0] DELTA_CW2   = -3'sd2;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // Result of evaluating one edge against the query point.
  typedef struct packed {
    logic                          on_bound;
    quad_t                         quad;
    logic signed [DELTA_BITS-1:0]  delta;
  } edge_res_t;

  function automatic quad_t quad_of(input logic neg_x, input logic neg_y);
    quad_t q;
    case ({neg_x, neg_y})
      2'b00:   q = QUAD_PP;
      2'b10:   q = QUAD_NP;
      2'b11:   q = QUAD_NN;
      2'b01:   q = QUAD_PN;
      default: q = QUAD_PP;
    endcase
    return q;
  endfunction

  // Winding sum plus a small step, clamped to the sum range.
  function automatic logic signed [SUM_BITS-1:0] sum_add(
    input logic signed [SUM_BITS-1:0]   sum,
    input logic signed [DELTA_BITS-1:0] delta
  );
    logic signed [SUM_BITS:0] ext;
    logic signed [SUM_BITS-1:0] res;
    ext = {sum[SUM_BITS-1], sum} + {{(SUM_BITS+1-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};
    if (ext[SUM_BITS] != ext[SUM_BITS-1]) begin
      res = ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      res = ext[SUM_BITS-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/pipw_edge.sv
// Edge evaluation: quadrant step, cross product compare and boundary test.
module pipw_edge
  import pipw_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS:0] dx_i,
  input  logic signed [COORD_BITS:0] dy_i,
  input  logic signed [COORD_BITS:0] prev_dx_i,
  input  logic signed [COORD_BITS:0] prev_dy_i,
  input  quad_t                      prev_quad_i,
  output edge_res_t                  res_o
);

  localparam int unsigned OffW  = COORD_BITS + 1;
  localparam int unsigned ProdW = 2 * OffW;

  logic signed [ProdW-1:0] pa;
  logic signed [ProdW-1:0] pb;
  logic                    np_x;
  logic                    np_y;
  quad_t                   q;

  assign pa = ProdW'(dy_i) * ProdW'(prev_dx_i);
  assign pb = ProdW'(dx_i) * ProdW'(prev_dy_i);

  // product of the two values is <= 0
  assign np_x = (dx_i == '0) || (prev_dx_i == '0) || (dx_i[OffW-1] != prev_dx_i[OffW-1]);
  assign np_y = (dy_i == '0) || (prev_dy_i == '0) || (dy_i[OffW-1] != prev_dy_i[OffW-1]);

  assign q = quad_of(dx_i[OffW-1], dy_i[OffW-1]);

  always_comb begin
    res_o.on_bound = (pa == pb) && np_x && np_y;
    res_o.quad     = q;
    if (q == quad_t'(prev_quad_i + 2'd1)) begin
      res_o.delta = DELTA_CCW1;
    end else if (q == quad_t'(prev_quad_i + 2'd3)) begin
      res_o.delta = DELTA_CW1;
    end else if (q == quad_t'(prev_quad_i + 2'd2)) begin
      // half turn: direction from the cross product sign
      res_o.delta = (pa > pb) ? DELTA_CCW2 : DELTA_CW2;
    end else begin
      res_o.delta = DELTA_ZERO;
    end
  end

endmodule

### rtl/point_in_polygon_winding_core.sv
// Top level: streaming point-in-polygon test by quadrant winding number.
// Timing: a corner request is registered, then evaluated in the next cycle; the result
// of a last corner is written to the output register as it leaves the input register.
// Throughput: one corner per cycle while no last corner waits behind an unread result.
// Reset: rst_ni clears the stage valids and all winding state (query, previous corner,
// sum, boundary hit) to zero.
module point_in_polygon_winding_core
  import pipw_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // query_x, query_y, corner_x, corner_y (lowest bits first), zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  input  logic                                  s_axis_tlast_i,   // last_corner
  input  logic                                  s_axis_tuser_i,   // first_corner
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [7:0]                            m_axis_tdata_o    // inside_res, zero padded
);

  localparam int unsigned OffW = COORD_BITS + 1;

  // input register
  logic                         s1_valid_q;
  logic signed [COORD_BITS-1:0] s1_qx_q, s1_qy_q, s1_cx_q, s1_cy_q;
  logic                         s1_first_q, s1_last_q;
  logic                         s1_adv;
  logic                         in_acc;

  // winding state
  logic signed [COORD_BITS-1:0] held_qx_q, held_qx_d;
  logic signed [COORD_BITS-1:0] held_qy_q, held_qy_d;
  logic signed [OffW-1:0]       prev_dx_q, prev_dx_d;
  logic signed [OffW-1:0]       prev_dy_q, prev_dy_d;
  quad_t                        prev_quad_q, prev_quad_d;
  logic signed [SUM_BITS-1:0]   sum_q, sum_d;
  logic                         hit_q, hit_d;

  // result register
  logic                         out_valid_q;
  logic                         inside_q;

  logic signed [COORD_BITS-1:0] qx, qy;
  logic signed [OffW-1:0]       dx, dy;
  edge_res_t                    edge_res;

  assign s1_adv          = s1_valid_q && (!s1_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_qx_q    <= s_axis_tdata_i[COORD_BITS-1:0];
      s1_qy_q    <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
      s1_cx_q    <= s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
      s1_cy_q    <= s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS];
      s1_first_q <= s_axis_tuser_i;
      s1_last_q  <= s_axis_tlast_i;
    end
  end

  // offsets use the fresh query point on a first corner
  assign qx = s1_first_q ? s1_qx_q : held_qx_q;
  assign qy = s1_first_q ? s1_qy_q : held_qy_q;
  assign dx = OffW'(s1_cx_q) - OffW'(qx);
  assign dy = OffW'(s1_cy_q) - OffW'(qy);

  pipw_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .dx_i        (dx),
    .dy_i        (dy),
    .prev_dx_i   (prev_dx_q),
    .prev_dy_i   (prev_dy_q),
    .prev_quad_i (prev_quad_q),
    .res_o       (edge_res)
  );

  always_comb begin
    held_qx_d   = held_qx_q;
    held_qy_d   = held_qy_q;
    prev_dx_d   = prev_dx_q;
    prev_dy_d   = prev_dy_q;
    prev_quad_d = prev_quad_q;
    sum_d       = sum_q;
    hit_d       = hit_q;
    if (s1_first_q) begin
      held_qx_d   = s1_qx_q;
      held_qy_d   = s1_qy_q;
      prev_dx_d   = dx;
      prev_dy_d   = dy;
      prev_quad_d = edge_res.quad;
      sum_d       = '0;
      hit_d       = 1'b0;
    end else if (!hit_q) begin
      // a corner on the point also shows up as a degenerate on-edge case
      if (edge_res.on_bound) begin
        hit_d = 1'b1;
      end else begin
        sum_d       = sum_add(sum_q, edge_res.delta);
        prev_quad_d = edge_res.quad;
        prev_dx_d   = dx;
        prev_dy_d   = dy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_qx_q   <= '0;
      held_qy_q   <= '0;
      prev_dx_q   <= '0;
      prev_dy_q   <= '0;
      prev_quad_q <= QUAD_PP;
      sum_q       <= '0;
      hit_q       <= 1'b0;
    end else if (s1_adv) begin
      held_qx_q   <= held_qx_d;
      held_qy_q   <= held_qy_d;
      prev_dx_q   <= prev_dx_d;
      prev_dy_q   <= prev_dy_d;
      prev_quad_q <= prev_quad_d;
      sum_q       <= sum_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      inside_q <= hit_d || (sum_d != '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, inside_q};

  // a last corner leaving the input register always lands a result
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> m_axis_tvalid_o)
    else $error("last corner produced no result");

  // input side only stalls while a last corner is held behind an unread result
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q && s1_last_q && out_valid_q)
    else $error("input stalled without a blocked last corner");

  // boundary hit stays until a new polygon opens
  a_hit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q && !(s1_adv && s1_first_q) |=> hit_q)
    else $error("boundary hit dropped inside a polygon");

endmodule
